// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the streaming hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned TotalW     = 61;

	typedef enum logic [1:0] {
		KIND_ABSORB  = 2'd0,
		KIND_DIGEST  = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD_LOAD,
		ST_PAD_ROUND,
		ST_PAD_FOLD,
		ST_EMIT
	} state_t;

	// Which block the message schedule loads its sixteen words from.
	typedef enum logic [1:0] {
		SRC_BUFFER,
		SRC_PAD_FIRST,
		SRC_PAD_SECOND
	} src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       write_byte;
		logic       restart;
		logic       load_word;
		logic [3:0] load_idx;
		src_t       src;
		logic       init_work;
		logic       round;
		logic [5:0] round_idx;
		logic       fold_chain;
		logic       fold_copy;
		logic       copy_from_chain;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill;
		logic       two_blocks;
	} stat_t;

	localparam logic [31:0] INIT_VEC [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hdl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte counter, chaining words, message schedule and one
// compression round per cycle.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      data_byte,
	input  sha_pkg::cmd_t   cmd,
	input  logic [2:0]      out_idx,
	output sha_pkg::stat_t  stat,
	output logic [31:0]     digest_word
);

	logic [31:0] buf_mem [sha_pkg::BlockWords];
	logic [31:0] buf_rd_q;
	logic [3:0]  rd_idx_q;
	logic [5:0]  fill_q;
	logic [sha_pkg::TotalW-1:0] total_q;
	logic [31:0] chain_q [8];
	logic [31:0] copy_q [8];
	logic [31:0] work_q [8];
	logic [31:0] sched_q [16];
	logic [31:0] load_word;
	logic [31:0] w_new;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [63:0] bit_len;
	logic [5:0]  pos;
	logic [7:0]  pb [4];

	assign bit_len = {total_q, 3'b000};
	assign stat.fill = fill_q;
	assign stat.two_blocks = (fill_q >= 6'd56);

	// The buffer is written one byte and read one word per cycle. The index
	// of the word read is kept beside it for the padding logic.
	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			buf_mem[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
		end
		buf_rd_q <= buf_mem[cmd.load_idx];
		rd_idx_q <= cmd.load_idx;
	end

	// Padding bytes of a word: held data below the fill mark, 0x80 at it, then
	// zeros, with the bit length in the last eight bytes of the final block.
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			pos = {rd_idx_q, 2'(b)};
			pb[b] = 8'h00;
			if (cmd.src == sha_pkg::SRC_PAD_FIRST) begin
				if (pos < fill_q) begin
					pb[b] = buf_rd_q[31 - 8*b -: 8];
				end else if (pos == fill_q) begin
					pb[b] = 8'h80;
				end
			end
		end
		load_word = {pb[0], pb[1], pb[2], pb[3]};
		if ((cmd.src == sha_pkg::SRC_PAD_SECOND) || !stat.two_blocks) begin
			if (rd_idx_q == 4'd14) begin
				load_word = bit_len[63:32];
			end else if (rd_idx_q == 4'd15) begin
				load_word = bit_len[31:0];
			end
		end
		if (cmd.src == sha_pkg::SRC_BUFFER) begin
			load_word = buf_rd_q;
		end
	end

	assign w_new = sched_q[0]
		+ (sha_pkg::ror(sched_q[1], 7) ^ sha_pkg::ror(sched_q[1], 18) ^ (sched_q[1] >> 3))
		+ sched_q[9]
		+ (sha_pkg::ror(sched_q[14], 17) ^ sha_pkg::ror(sched_q[14], 19)
			^ (sched_q[14] >> 10));
	assign w_cur = sched_q[0];

	assign t1 = work_q[7]
		+ (sha_pkg::ror(work_q[4], 6) ^ sha_pkg::ror(work_q[4], 11)
			^ sha_pkg::ror(work_q[4], 25))
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ sha_pkg::ROUND_K[cmd.round_idx] + w_cur;
	assign t2 = (sha_pkg::ror(work_q[0], 2) ^ sha_pkg::ror(work_q[0], 13)
			^ sha_pkg::ror(work_q[0], 22))
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::INIT_VEC[i];
			end
		end else begin
			if (cmd.restart) begin
				fill_q  <= '0;
				total_q <= '0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha_pkg::INIT_VEC[i];
				end
			end else begin
				if (cmd.write_byte) begin
					fill_q  <= fill_q + 6'd1;
					total_q <= total_q + sha_pkg::TotalW'(1);
				end
				if (cmd.fold_chain) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= load_word;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= w_new;
		end
		if (cmd.copy_from_chain) begin
			copy_q <= chain_q;
		end else if (cmd.fold_copy) begin
			for (int i = 0; i < 8; i++) begin
				copy_q[i] <= copy_q[i] + work_q[i];
			end
		end
		if (cmd.init_work) begin
			work_q <= cmd.copy_from_chain ? chain_q : copy_q;
		end else if (cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	assign digest_word = copy_q[out_idx];

`ifndef SYNTHESIS
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> (fill_q == 6'd0) && (total_q == '0))
		else $error("restart left the counters set");
	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_byte && !cmd.restart |=> fill_q == $past(fill_q) + 6'd1)
		else $error("fill count did not advance");
	a_chain_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.fold_chain && !cmd.restart |=> $stable(chain_q[0]))
		else $error("chaining word changed outside a fold");
`endif

endmodule

// ===== hdl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      kind,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      out_idx,
	input  sha_pkg::stat_t  stat,
	output sha_pkg::cmd_t   cmd
);

	sha_pkg::state_t state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic       second_q, second_d;
	logic       in_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_idx = cnt_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha_pkg::ST_IDLE;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			second_q <= second_d;
		end
	end

	// Loading takes 17 steps: a buffer read is registered in the cycle before
	// its shift into the schedule.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		second_d = second_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		cmd = '0;
		cmd.src = second_q ? sha_pkg::SRC_PAD_SECOND : sha_pkg::SRC_PAD_FIRST;
		cmd.load_idx = cnt_q[3:0];
		cmd.round_idx = cnt_q[5:0];
		case (state_q)
			sha_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (kind)
						sha_pkg::KIND_ABSORB: begin
							cmd.write_byte = 1'b1;
							if (stat.fill == 6'd63) begin
								state_d = sha_pkg::ST_LOAD;
								cnt_d = '0;
							end
						end
						sha_pkg::KIND_RESTART: cmd.restart = 1'b1;
						sha_pkg::KIND_DIGEST: begin
							cmd.copy_from_chain = 1'b1;
							state_d = sha_pkg::ST_PAD_LOAD;
							second_d = 1'b0;
							cnt_d = '0;
						end
						default: ;
					endcase
				end
			end
			sha_pkg::ST_LOAD, sha_pkg::ST_PAD_LOAD: begin
				cmd.src = (state_q == sha_pkg::ST_LOAD) ? sha_pkg::SRC_BUFFER : cmd.src;
				cmd.load_idx = cnt_q[3:0] - 4'd1;
				cmd.load_word = (cnt_q != 7'd0);
				if (cnt_q == 7'd16) begin
					cmd.init_work = 1'b1;
					cmd.copy_from_chain = 1'b0;
					state_d = (state_q == sha_pkg::ST_LOAD) ? sha_pkg::ST_ROUND
						: sha_pkg::ST_PAD_ROUND;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
				if (state_q == sha_pkg::ST_LOAD && cnt_q == 7'd16) begin
					cmd.copy_from_chain = 1'b1;
				end
				if (cnt_q != 7'd16) begin
					cmd.load_idx = cnt_q[3:0];
				end
			end
			sha_pkg::ST_ROUND, sha_pkg::ST_PAD_ROUND: begin
				cmd.round = 1'b1;
				if (cnt_q == 7'd63) begin
					state_d = (state_q == sha_pkg::ST_ROUND) ? sha_pkg::ST_FOLD
						: sha_pkg::ST_PAD_FOLD;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			sha_pkg::ST_FOLD: begin
				cmd.fold_chain = 1'b1;
				state_d = sha_pkg::ST_IDLE;
			end
			sha_pkg::ST_PAD_FOLD: begin
				cmd.fold_copy = 1'b1;
				cnt_d = '0;
				if (stat.two_blocks && !second_q) begin
					second_d = 1'b1;
					state_d = sha_pkg::ST_PAD_LOAD;
				end else begin
					state_d = sha_pkg::ST_EMIT;
				end
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (cnt_q == 7'd7) begin
						state_d = sha_pkg::ST_IDLE;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + 7'd1;
					end
				end
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
		if (!in_acc) begin
			cmd.write_byte = cmd.write_byte & in_acc;
		end
	end

`ifndef SYNTHESIS
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == sha_pkg::ST_EMIT)
		else $error("result outside emit");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sha_pkg::ST_IDLE) |-> in_stall)
		else $error("accepted while busy");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> cnt_q < 7'd64)
		else $error("round index out of range");
`endif

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// Streaming SHA-256 hasher
// Absorbs message bytes and emits the digest of the stream on request.
// ----------------------------------------------------------------------------
// Input channel: kind and data_byte, qualified by in_valid and in_stall.
// Kind 0 absorbs data_byte, kind 1 asks for the digest of all bytes so far
// without disturbing the running hash, kind 2 restarts from the initial
// vector, kind 3 is dropped.
// Output channel: eight words per digest request, digest_word with its
// word_index, last_word set on word 7, qualified by out_valid and out_stall.
// An absorbed byte is written into the block buffer; the 64th byte of a block adds
// a compression (schedule load, 64 rounds on the single round unit, one fold). A digest adds
// the same work for each padded block, one or two in all, after the accepting cycle,
// then one word per cycle unless stalled.
// The block works on one item at a time and holds in_stall high meanwhile.
// Reset loads the initial vector and clears the byte counters; a stalled
// word holds until taken.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_pkg::cmd_t  cmd;
	sha_pkg::stat_t stat;
	logic [2:0]     out_idx;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_idx   (out_idx),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.out_idx     (out_idx),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign word_index = out_idx;
	assign last_word  = (out_idx == 3'd7);

endmodule
